// ----- rtl/lobm_pkg.sv -----
// lobm_pkg: shared types, constants and helpers for the order book matcher
// depends on nothing; used by lobm_dp, lobm_ctrl and the top module
package lobm_pkg;

	localparam int unsigned BOOK_DEPTH_DEF = 1024;
	localparam logic [29:0] MODULUS = 30'd1000000007;
	localparam logic [59:0] MASK60 = 60'hFFF_FFFF_FFFF_FFFF;

	// one incoming order
	typedef struct packed {
		logic [29:0] price;
		logic [29:0] amount;
		logic        side;
	} in_t;

	// one result
	typedef struct packed {
		logic [29:0] backlog_mod;
		logic [29:0] filled_amount;
		logic [29:0] rested_amount;
		logic        book_full;
	} out_t;

	// read address source
	typedef enum logic [2:0] {
		R_ZERO   = 3'd0,
		R_CNT    = 3'd1,
		R_LEFT   = 3'd2,
		R_RIGHT  = 3'd3,
		R_PARENT = 3'd4
	} rsel_t;

	// write data source
	typedef enum logic [1:0] {
		W_VAL = 2'd0,
		W_CLD = 2'd1,
		W_RD  = 2'd2
	} wsel_t;

	// controller to datapath
	typedef struct packed {
		logic  own;        // 1: own book, 0: opposite book
		rsel_t rsel;
		wsel_t wsel;
		logic  we;
		logic  load_in;
		logic  fill_all;
		logic  fill_part;
		logic  pop_load;
		logic  cld_left;
		logic  cld_right;
		logic  idx_child;
		logic  rest_push;
		logic  set_full;
		logic  idx_parent;
		logic  tot_sub;
		logic  tot_add;
		logic  load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic amt_zero;
		logic cur_empty;
		logic cur_full;
		logic top_ok;
		logic top_all;
		logic l_in;
		logic r_in;
		logic r_gt;
		logic c_gt;
		logic idx_zero;
		logic p_ge;
		logic out_busy;
	} stat_t;

	// sell book stores the complement so both books are max-heaps
	function automatic logic [59:0] flip(input logic [59:0] w, input logic is_sell);
		return is_sell ? (MASK60 - w) : w;
	endfunction

endpackage

// ----- rtl/lobm_ram.sv -----
// lobm_ram: generic one-write one-read RAM with registered read
// depends on nothing
module lobm_ram #(
	parameter int unsigned WIDTH = 60,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/lobm_dp.sv -----
// lobm_dp: datapath with both heaps, counts, order registers and backlog total
// depends on lobm_pkg and lobm_ram
module lobm_dp
	import lobm_pkg::*;
#(
	parameter int unsigned BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  in_t   in_data,
	input  logic  out_ready,
	output logic  out_valid,
	output out_t  out_data,
	input  cmd_t  cmd,
	output stat_t stat
);
	localparam int unsigned AW = $clog2(BOOK_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

	logic [29:0]   price_q, amt_q, filled_q, rested_q, total_q;
	logic          side_q, full_q;
	logic [CW-1:0] buy_cnt_q, sell_cnt_q;
	logic [AW-1:0] idx_q, cidx_q;
	logic [59:0]   val_q, cld_q;
	logic          out_valid_q;
	out_t          out_q;

	logic          cur_sell;
	logic [CW-1:0] cur_cnt;
	logic [59:0]   rd_buy, rd_sell, rdata, wdata, top_key;
	logic [29:0]   rp, ra;
	logic [CW:0]   lch, rch;
	logic [AW-1:0] par, raddr;
	logic [29:0]   fm, rm;
	logic [30:0]   sub_t, add_t;

	// book in use and its view
	assign cur_sell = cmd.own ? side_q : ~side_q;
	assign cur_cnt  = cur_sell ? sell_cnt_q : buy_cnt_q;
	assign rdata    = cur_sell ? rd_sell : rd_buy;
	assign top_key  = flip(rdata, cur_sell);
	assign rp       = top_key[59:30];
	assign ra       = top_key[29:0];
	assign lch      = {idx_q, 1'b1} + (CW+1)'(0);
	assign rch      = lch + (CW+1)'(1);
	assign par      = (idx_q - AW'(1)) >> 1;

	// read address select
	always_comb begin
		unique case (cmd.rsel)
			R_ZERO:   raddr = '0;
			R_CNT:    raddr = cur_cnt[AW-1:0];
			R_LEFT:   raddr = lch[AW-1:0];
			R_RIGHT:  raddr = rch[AW-1:0];
			R_PARENT: raddr = par;
			default:  raddr = '0;
		endcase
	end

	// write data select
	always_comb begin
		unique case (cmd.wsel)
			W_VAL:   wdata = val_q;
			W_CLD:   wdata = cld_q;
			W_RD:    wdata = rdata;
			default: wdata = val_q;
		endcase
	end

	lobm_ram #(.WIDTH(60), .DEPTH(BOOK_DEPTH)) u_buy (
		.clk(clk), .we(cmd.we && !cur_sell), .waddr(idx_q), .wdata(wdata),
		.raddr(raddr), .rdata(rd_buy)
	);

	lobm_ram #(.WIDTH(60), .DEPTH(BOOK_DEPTH)) u_sell (
		.clk(clk), .we(cmd.we && cur_sell), .waddr(idx_q), .wdata(wdata),
		.raddr(raddr), .rdata(rd_sell)
	);

	// status to controller
	assign stat.amt_zero  = (amt_q == '0);
	assign stat.cur_empty = (cur_cnt == '0);
	assign stat.cur_full  = (cur_cnt >= DEPTH_C);
	assign stat.top_ok    = side_q ? (rp >= price_q) : (rp <= price_q);
	assign stat.top_all   = (ra <= amt_q);
	assign stat.l_in      = (lch < {1'b0, cur_cnt});
	assign stat.r_in      = (rch < {1'b0, cur_cnt});
	assign stat.r_gt      = (rdata > cld_q);
	assign stat.c_gt      = (cld_q > val_q);
	assign stat.idx_zero  = (idx_q == '0);
	assign stat.p_ge      = (rdata >= val_q);
	assign stat.out_busy  = out_valid_q && !out_ready;

	// modular backlog steps
	assign fm    = (filled_q >= MODULUS) ? (filled_q - MODULUS) : filled_q;
	assign rm    = (rested_q >= MODULUS) ? (rested_q - MODULUS) : rested_q;
	assign sub_t = (total_q >= fm) ? {1'b0, total_q - fm}
	                               : ({1'b0, total_q} + {1'b0, MODULUS} - {1'b0, fm});
	assign add_t = {1'b0, total_q} + {1'b0, rm};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buy_cnt_q   <= '0;
			sell_cnt_q  <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_all) begin
				if (cur_sell) sell_cnt_q <= sell_cnt_q - CW'(1);
				else          buy_cnt_q  <= buy_cnt_q - CW'(1);
			end
			if (cmd.rest_push) begin
				if (cur_sell) sell_cnt_q <= sell_cnt_q + CW'(1);
				else          buy_cnt_q  <= buy_cnt_q + CW'(1);
			end
			if (cmd.tot_sub) total_q <= sub_t[29:0];
			if (cmd.tot_add) total_q <= (add_t >= {1'b0, MODULUS}) ?
				30'(add_t - {1'b0, MODULUS}) : add_t[29:0];
			if (cmd.load_out)     out_valid_q <= 1'b1;
			else if (out_ready)   out_valid_q <= 1'b0;
		end
	end

	// order and heap walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			price_q  <= in_data.price;
			amt_q    <= in_data.amount;
			side_q   <= in_data.side;
			filled_q <= '0;
			rested_q <= '0;
			full_q   <= 1'b0;
		end
		if (cmd.fill_all) begin
			filled_q <= filled_q + ra;
			amt_q    <= amt_q - ra;
		end
		if (cmd.fill_part) begin
			filled_q <= filled_q + amt_q;
			amt_q    <= '0;
			val_q    <= flip({rp, ra - amt_q}, cur_sell);
			idx_q    <= '0;
		end
		if (cmd.pop_load) begin
			val_q <= rdata;
			idx_q <= '0;
		end
		if (cmd.cld_left) begin
			cld_q  <= rdata;
			cidx_q <= lch[AW-1:0];
		end
		if (cmd.cld_right && stat.r_gt) begin
			cld_q  <= rdata;
			cidx_q <= rch[AW-1:0];
		end
		if (cmd.idx_child)  idx_q <= cidx_q;
		if (cmd.idx_parent) idx_q <= par;
		if (cmd.rest_push) begin
			rested_q <= amt_q;
			val_q    <= flip({price_q, amt_q}, cur_sell);
			idx_q    <= cur_cnt[AW-1:0];
		end
		if (cmd.set_full) full_q <= 1'b1;
		if (cmd.load_out) begin
			out_q.backlog_mod   <= total_q;
			out_q.filled_amount <= filled_q;
			out_q.rested_amount <= rested_q;
			out_q.book_full     <= full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// counts stay within the book, total stays reduced
	a_buy_cnt: assert property (@(posedge clk) disable iff (!arst_n) buy_cnt_q <= DEPTH_C)
		else $error("buy count beyond depth");
	a_sell_cnt: assert property (@(posedge clk) disable iff (!arst_n) sell_cnt_q <= DEPTH_C)
		else $error("sell count beyond depth");
	a_total: assert property (@(posedge clk) disable iff (!arst_n) total_q < MODULUS)
		else $error("backlog not reduced");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest_push |-> !stat.cur_full)
		else $error("push into full book");
endmodule

// ----- rtl/lobm_ctrl.sv -----
// lobm_ctrl: sequencer for matching, heap sift down/up and result hand-off
// depends on lobm_pkg
module lobm_ctrl
	import lobm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_CHK   = 15'b000000000000010,
		S_TOP   = 15'b000000000000100,
		S_POPA  = 15'b000000000001000,
		S_POPB  = 15'b000000000010000,
		S_SDL   = 15'b000000000100000,
		S_SDLW  = 15'b000000001000000,
		S_SDRW  = 15'b000000010000000,
		S_SDCMP = 15'b000000100000000,
		S_REST  = 15'b000001000000000,
		S_SU    = 15'b000010000000000,
		S_SUW   = 15'b000100000000000,
		S_FIN   = 15'b001000000000000,
		S_FIN2  = 15'b010000000000000,
		S_OUT   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rsel = R_ZERO;
		cmd.wsel = W_VAL;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.amt_zero || stat.cur_empty) state_d = S_REST;
				else                                 state_d = S_TOP;
			end
			S_TOP: begin
				if (!stat.top_ok) begin
					state_d = S_REST;
				end else if (stat.top_all) begin
					cmd.fill_all = 1'b1;
					state_d      = S_POPA;
				end else begin
					cmd.fill_part = 1'b1;
					state_d       = S_SDL;
				end
			end
			S_POPA: begin
				cmd.rsel = R_CNT;
				state_d  = S_POPB;
			end
			S_POPB: begin
				if (stat.cur_empty) begin
					state_d = S_CHK;
				end else begin
					cmd.pop_load = 1'b1;
					state_d      = S_SDL;
				end
			end
			S_SDL: begin
				if (stat.l_in) begin
					cmd.rsel = R_LEFT;
					state_d  = S_SDLW;
				end else begin
					cmd.we  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_SDLW: begin
				cmd.cld_left = 1'b1;
				if (stat.r_in) begin
					cmd.rsel = R_RIGHT;
					state_d  = S_SDRW;
				end else begin
					state_d = S_SDCMP;
				end
			end
			S_SDRW: begin
				cmd.cld_right = 1'b1;
				state_d       = S_SDCMP;
			end
			S_SDCMP: begin
				cmd.we = 1'b1;
				if (stat.c_gt) begin
					cmd.wsel      = W_CLD;
					cmd.idx_child = 1'b1;
					state_d       = S_SDL;
				end else begin
					state_d = S_CHK;
				end
			end
			S_REST: begin
				cmd.own = 1'b1;
				if (stat.amt_zero) begin
					state_d = S_FIN;
				end else if (stat.cur_full) begin
					cmd.set_full = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.rest_push = 1'b1;
					state_d       = S_SU;
				end
			end
			S_SU: begin
				cmd.own = 1'b1;
				if (stat.idx_zero) begin
					cmd.we  = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.rsel = R_PARENT;
					state_d  = S_SUW;
				end
			end
			S_SUW: begin
				cmd.own = 1'b1;
				cmd.we  = 1'b1;
				if (stat.p_ge) begin
					state_d = S_FIN;
				end else begin
					cmd.wsel       = W_RD;
					cmd.idx_parent = 1'b1;
					state_d        = S_SU;
				end
			end
			S_FIN: begin
				cmd.tot_sub = 1'b1;
				state_d     = S_FIN2;
			end
			S_FIN2: begin
				cmd.tot_add = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// a new beat is only taken with nothing in flight
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHK))
		else $error("accepted beat did not start matching");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !cmd.we)
		else $error("heap write while idle");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == S_IDLE))
		else $error("result load not followed by idle");
endmodule

// ----- rtl/limit_order_book_matcher_top.sv -----
// limit_order_book_matcher_top: order matcher with buy and sell heap books
// depends on lobm_pkg, lobm_ctrl, lobm_dp (which holds two lobm_ram)
//
// usage: one limit order per input beat (price, amount, side) on in_valid /
// in_ready; one result beat per order on out_valid / out_ready carrying the
// backlog total mod 1000000007, filled and rested units and the full flag.
// orders are processed one at a time; in_ready is high only when idle.
// each sift-down heap level runs on the single read port of a book memory:
// read left child, read right child (if present), compare, write.
// the result sits in an output register; a stalled receiver holds it there
// while the next order is already accepted and matched, and that order only
// waits at its own hand-off until the register frees.
// reset (arst_n low) empties both books and zeroes the total at once; the
// book memories need no clearing pass since only entries below the counts
// are ever read.
module limit_order_book_matcher_top
	import lobm_pkg::*;
#(
	parameter int unsigned BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);
	cmd_t  cmd;
	stat_t stat;

	lobm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	lobm_dp #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .out_ready(out_ready),
		.out_valid(out_valid), .out_data(out_data), .cmd(cmd), .stat(stat)
	);
endmodule
